### hdl/boat_plant_euler_step_unit_defines.svh
// ----------------------------------------------------------------------------
// boat plant euler step unit: assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BOAT_PLANT_EULER_STEP_UNIT_DEFINES_SVH
`define BOAT_PLANT_EULER_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define BPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// types, constants and the microprogram of the boat plant euler step unit
// ----------------------------------------------------------------------------
package bpe_pkg;

  // default number format
  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  // configuration port
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(655);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = CFG_IDX_W'(1);

  // multiplier digit width (operand b is taken one digit per cycle)
  localparam int MUL_CHUNK = 16;

  // plant coefficients in Q.32
  localparam longint Q32_ONE       = 64'sd4294967296;
  localparam longint Q32_HALF      = Q32_ONE / 2;
  localparam longint Q32_3QTR      = 3 * (Q32_ONE / 4);
  localparam longint C_DEG2RAD     = 64'sd74961321;
  localparam longint C_RAD2DEG     = 64'sd246083499208;
  localparam longint C_RPM_PER_RAD = 64'sd41013916535;
  localparam longint C_0015        = 64'sd64424509;
  localparam longint C_099         = 64'sd4252017623;

  // sequencer microprogram length
  localparam int UC_LEN = 43;
  localparam int PC_W   = 6;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_NEG,
    OP_MAX,
    OP_MIN,
    OP_MUL
  } op_t;

  // operand and destination locations
  typedef enum logic [5:0] {
    L_PS, L_PA, L_HS, L_HA, L_RA, L_RR, L_YA, L_YR,
    L_PWR, L_TA, L_TB, L_TC, L_PD0, L_PD1, L_VD0, L_VD1, L_RD, L_YD1,
    L_IN_PWR, L_IN_RDEG, L_DT, L_SG,
    L_ZERO, L_ONE, L_P20, L_N20, L_DEG2RAD, L_M2, L_P500, L_MHALF,
    L_M075, L_P0015, L_M3, L_M099, L_HALF, L_RPM, L_RAD2DEG
  } loc_t;

  typedef struct packed {
    op_t  op;
    loc_t dst;
    loc_t sa;
    loc_t sb;
  } uop_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_ISSUE,
    SS_WAIT,
    SS_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_ACC,
    AS_FIN
  } alu_state_t;

  // Q.32 constant to Q.fb, round half away from zero, saturate to dw bits
  function automatic logic signed [63:0] q_const(input longint k, input int fb,
                                                  input int dw);
    logic [63:0] m;
    logic [63:0] lim;
    logic signed [63:0] r;
    m   = (k < 0) ? 64'(-k) : 64'(k);
    m   = (m + (64'd1 << (31 - fb))) >> (32 - fb);
    lim = (64'd1 << (dw - 1)) - 64'd1;
    if (m > lim) begin
      r = (k < 0) ? $signed(~lim) : $signed(lim);
    end else begin
      r = (k < 0) ? -$signed(m) : $signed(m);
    end
    return r;
  endfunction

  function automatic uop_t uo(input op_t op, input loc_t d, input loc_t a, input loc_t b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  // one micro-op per step: input clamps, derivatives from old state, then updates, then outputs
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // input clamps and degree to radian
      6'd0:  u = uo(OP_MAX, L_PWR, L_IN_PWR, L_ZERO);
      6'd1:  u = uo(OP_MIN, L_PWR, L_PWR, L_ONE);
      6'd2:  u = uo(OP_MAX, L_RD, L_IN_RDEG, L_N20);
      6'd3:  u = uo(OP_MIN, L_RD, L_RD, L_P20);
      6'd4:  u = uo(OP_MUL, L_RD, L_RD, L_DEG2RAD);
      // propeller
      6'd5:  u = uo(OP_NEG, L_TA, L_PS, L_ZERO);
      6'd6:  u = uo(OP_ADD, L_PD0, L_TA, L_PA);
      6'd7:  u = uo(OP_MUL, L_TA, L_M2, L_PA);
      6'd8:  u = uo(OP_MUL, L_TB, L_P500, L_PWR);
      6'd9:  u = uo(OP_ADD, L_PD1, L_TA, L_TB);
      // hull
      6'd10: u = uo(OP_MUL, L_TA, L_MHALF, L_HS);
      6'd11: u = uo(OP_ADD, L_VD0, L_TA, L_HA);
      6'd12: u = uo(OP_MUL, L_TA, L_M075, L_HA);
      6'd13: u = uo(OP_MUL, L_TB, L_P0015, L_PS);
      6'd14: u = uo(OP_ADD, L_VD1, L_TA, L_TB);
      // rudder
      6'd15: u = uo(OP_NEG, L_TA, L_RA, L_ZERO);
      6'd16: u = uo(OP_MUL, L_TB, L_M3, L_RR);
      6'd17: u = uo(OP_ADD, L_TA, L_TA, L_TB);
      6'd18: u = uo(OP_ADD, L_RD, L_TA, L_RD);
      // yaw, input gain from squared speed
      6'd19: u = uo(OP_MUL, L_TA, L_HS, L_HS);
      6'd20: u = uo(OP_MUL, L_TA, L_TA, L_SG);
      6'd21: u = uo(OP_MUL, L_TB, L_M099, L_YR);
      6'd22: u = uo(OP_MUL, L_TC, L_HALF, L_RA);
      6'd23: u = uo(OP_MUL, L_TC, L_TC, L_TA);
      6'd24: u = uo(OP_ADD, L_YD1, L_TB, L_TC);
      // euler updates
      6'd25: u = uo(OP_MUL, L_TA, L_PD0, L_DT);
      6'd26: u = uo(OP_ADD, L_PS, L_PS, L_TA);
      6'd27: u = uo(OP_MUL, L_TA, L_PD1, L_DT);
      6'd28: u = uo(OP_ADD, L_PA, L_PA, L_TA);
      6'd29: u = uo(OP_MUL, L_TA, L_VD0, L_DT);
      6'd30: u = uo(OP_ADD, L_HS, L_HS, L_TA);
      6'd31: u = uo(OP_MUL, L_TA, L_VD1, L_DT);
      6'd32: u = uo(OP_ADD, L_HA, L_HA, L_TA);
      6'd33: u = uo(OP_MUL, L_TA, L_RR, L_DT);
      6'd34: u = uo(OP_ADD, L_RA, L_RA, L_TA);
      6'd35: u = uo(OP_MUL, L_TA, L_RD, L_DT);
      6'd36: u = uo(OP_ADD, L_RR, L_RR, L_TA);
      6'd37: u = uo(OP_MUL, L_TA, L_YR, L_DT);
      6'd38: u = uo(OP_ADD, L_YA, L_YA, L_TA);
      6'd39: u = uo(OP_MUL, L_TA, L_YD1, L_DT);
      6'd40: u = uo(OP_ADD, L_YR, L_YR, L_TA);
      // output scaling
      6'd41: u = uo(OP_MUL, L_TA, L_PS, L_RPM);
      6'd42: u = uo(OP_MUL, L_TB, L_YA, L_RAD2DEG);
      default: u = uo(OP_ADD, L_TC, L_ZERO, L_ZERO);
    endcase
    return u;
  endfunction

endpackage

### hdl/boat_plant_euler_step_unit.sv
// ----------------------------------------------------------------------------
// boat_plant_euler_step_unit
// One beat on the in_ channel (motor power, rudder setpoint) advances the
// propeller, hull, rudder and yaw plants by one forward-euler step and gives
// one beat on the out_ channel (propeller rpm, hull speed, yaw in degrees).
// cfg_ writes set time_step (index 0) and speed_gain (index 1); write only
// while no beat is in flight. cfg_ready is always high.
// A small sequencer runs a 43-step microprogram through one shared unit:
// 22 multiplies, which take operand b in NCH = ceil(DATA_WIDTH / 16) digits,
// and 21 add, negate, max and min ops; each step is issued, waited on and
// written back before the next, and the output register is loaded last.
// in_ready is high only while the sequencer is idle, so a new beat is taken
// only once the previous beat's result has gone into the output register.
// A finished result waits in the output register; a stalled receiver holds it
// there, the next beat is still taken, and that beat's result waits until the
// register frees up.
// Reset clears all plant state, sets both registers to 655, drops out_valid.
// ----------------------------------------------------------------------------
`include "boat_plant_euler_step_unit_defines.svh"

module boat_plant_euler_step_unit #(
  parameter int DATA_WIDTH = bpe_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = bpe_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      in_motor_power,
  input  logic signed [DATA_WIDTH-1:0]      in_rudder_setpoint,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_shaft_rpm,
  output logic signed [DATA_WIDTH-1:0]      out_boat_speed_out,
  output logic signed [DATA_WIDTH-1:0]      out_yaw_deg,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpe_pkg::CFG_W-1:0]         cfg_wdata
);
  import bpe_pkg::*;

  // plant coefficients in the working format
  localparam logic signed [63:0] TWENTY_Q = q_const(20 * Q32_ONE, FRAC_BITS, DATA_WIDTH);
  localparam logic signed [DATA_WIDTH-1:0] K_ONE =
    DATA_WIDTH'(q_const(Q32_ONE, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_P20 = DATA_WIDTH'(TWENTY_Q);
  localparam logic signed [DATA_WIDTH-1:0] K_N20 = DATA_WIDTH'(-TWENTY_Q);
  localparam logic signed [DATA_WIDTH-1:0] K_DEG2RAD =
    DATA_WIDTH'(q_const(C_DEG2RAD, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_M2 =
    DATA_WIDTH'(q_const(-2 * Q32_ONE, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_P500 =
    DATA_WIDTH'(q_const(500 * Q32_ONE, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_MHALF =
    DATA_WIDTH'(q_const(-Q32_HALF, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_M075 =
    DATA_WIDTH'(q_const(-Q32_3QTR, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_P0015 =
    DATA_WIDTH'(q_const(C_0015, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_M3 =
    DATA_WIDTH'(q_const(-3 * Q32_ONE, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_M099 =
    DATA_WIDTH'(q_const(-C_099, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_HALF =
    DATA_WIDTH'(q_const(Q32_HALF, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_RPM =
    DATA_WIDTH'(q_const(C_RPM_PER_RAD, FRAC_BITS, DATA_WIDTH));
  localparam logic signed [DATA_WIDTH-1:0] K_RAD2DEG =
    DATA_WIDTH'(q_const(C_RAD2DEG, FRAC_BITS, DATA_WIDTH));

  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            uop;
  alu_ctl_t        alu_ctl;
  logic            alu_done;
  logic            wr_en;
  logic            out_load;
  logic            out_valid_r;

  logic signed [DATA_WIDTH-1:0] alu_a, alu_b, alu_res;

  // configuration registers
  logic [CFG_W-1:0] time_step_r, speed_gain_r;

  // accepted beat
  logic signed [DATA_WIDTH-1:0] pwr_in_r, rdeg_in_r;

  // plant state
  logic signed [DATA_WIDTH-1:0] ps_r, pa_r, hs_r, ha_r, ra_r, rr_r, ya_r, yr_r;

  // scratch values
  logic signed [DATA_WIDTH-1:0] t_pwr_r, t_a_r, t_b_r, t_c_r;
  logic signed [DATA_WIDTH-1:0] t_pd0_r, t_pd1_r, t_vd0_r, t_vd1_r, t_rd_r, t_yd1_r;

  // result register
  logic signed [DATA_WIDTH-1:0] rpm_out_r, speed_out_r, yaw_out_r;

  // operand select
  function automatic logic signed [DATA_WIDTH-1:0] pick(input loc_t l);
    logic signed [DATA_WIDTH-1:0] v;
    unique case (l)
      L_PS:      v = ps_r;
      L_PA:      v = pa_r;
      L_HS:      v = hs_r;
      L_HA:      v = ha_r;
      L_RA:      v = ra_r;
      L_RR:      v = rr_r;
      L_YA:      v = ya_r;
      L_YR:      v = yr_r;
      L_PWR:     v = t_pwr_r;
      L_TA:      v = t_a_r;
      L_TB:      v = t_b_r;
      L_TC:      v = t_c_r;
      L_PD0:     v = t_pd0_r;
      L_PD1:     v = t_pd1_r;
      L_VD0:     v = t_vd0_r;
      L_VD1:     v = t_vd1_r;
      L_RD:      v = t_rd_r;
      L_YD1:     v = t_yd1_r;
      L_IN_PWR:  v = pwr_in_r;
      L_IN_RDEG: v = rdeg_in_r;
      L_DT:      v = $signed(DATA_WIDTH'(time_step_r));
      L_SG:      v = $signed(DATA_WIDTH'(speed_gain_r));
      L_ZERO:    v = '0;
      L_ONE:     v = K_ONE;
      L_P20:     v = K_P20;
      L_N20:     v = K_N20;
      L_DEG2RAD: v = K_DEG2RAD;
      L_M2:      v = K_M2;
      L_P500:    v = K_P500;
      L_MHALF:   v = K_MHALF;
      L_M075:    v = K_M075;
      L_P0015:   v = K_P0015;
      L_M3:      v = K_M3;
      L_M099:    v = K_M099;
      L_HALF:    v = K_HALF;
      L_RPM:     v = K_RPM;
      L_RAD2DEG: v = K_RAD2DEG;
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign uop = ucode(pc_r);

  // operands follow both the micro-op and the registers it reads
  always_comb begin
    alu_a = pick(uop.sa);
    alu_b = pick(uop.sb);
  end

  bpe_alu #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  // sequencer: issue a micro-op, wait for the unit, write back, next step
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = uop.op;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      SS_IDLE: begin
        if (in_valid) begin
          state_nxt = SS_ISSUE;
          pc_nxt    = '0;
        end
      end
      SS_ISSUE: begin
        alu_ctl.start = 1'b1;
        state_nxt     = SS_WAIT;
      end
      SS_WAIT: begin
        if (alu_done) begin
          wr_en = 1'b1;
          if (pc_r == PC_W'(UC_LEN - 1)) begin
            state_nxt = SS_DONE;
          end else begin
            pc_nxt    = pc_r + PC_W'(1);
            state_nxt = SS_ISSUE;
          end
        end
      end
      SS_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = SS_IDLE;
        end
      end
      default: state_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign in_ready = (state_r == SS_IDLE);

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pwr_in_r  <= in_motor_power;
      rdeg_in_r <= in_rudder_setpoint;
    end
  end

  // configuration writes, unknown index ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r  <= CFG_RESET;
      speed_gain_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP:  time_step_r  <= cfg_wdata;
        REG_SPEED_GAIN: speed_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // plant state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= '0;
      pa_r <= '0;
      hs_r <= '0;
      ha_r <= '0;
      ra_r <= '0;
      rr_r <= '0;
      ya_r <= '0;
      yr_r <= '0;
    end else if (wr_en) begin
      case (uop.dst)
        L_PS:    ps_r <= alu_res;
        L_PA:    pa_r <= alu_res;
        L_HS:    hs_r <= alu_res;
        L_HA:    ha_r <= alu_res;
        L_RA:    ra_r <= alu_res;
        L_RR:    rr_r <= alu_res;
        L_YA:    ya_r <= alu_res;
        L_YR:    yr_r <= alu_res;
        default: ;
      endcase
    end
  end

  // scratch write-back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (uop.dst)
        L_PWR:   t_pwr_r <= alu_res;
        L_TA:    t_a_r   <= alu_res;
        L_TB:    t_b_r   <= alu_res;
        L_TC:    t_c_r   <= alu_res;
        L_PD0:   t_pd0_r <= alu_res;
        L_PD1:   t_pd1_r <= alu_res;
        L_VD0:   t_vd0_r <= alu_res;
        L_VD1:   t_vd1_r <= alu_res;
        L_RD:    t_rd_r  <= alu_res;
        L_YD1:   t_yd1_r <= alu_res;
        default: ;
      endcase
    end
  end

  // output register: rpm and yaw come from the last two steps
  always_ff @(posedge clk) begin
    if (out_load) begin
      rpm_out_r   <= t_a_r;
      speed_out_r <= hs_r;
      yaw_out_r   <= t_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shaft_rpm      = rpm_out_r;
  assign out_boat_speed_out = speed_out_r;
  assign out_yaw_deg        = yaw_out_r;

  // accepted beat starts the microprogram at its first step
  `BPE_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == SS_ISSUE && pc_r == '0, "accepted beat did not start the sequencer")
  // the shared unit only finishes while the sequencer waits on it
  `BPE_ASSERT_IMPL(a_done_in_wait, alu_done, state_r == SS_WAIT, "unit finished outside the wait state")
  // a new result only appears after the last step
  `BPE_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == SS_DONE, "result raised without a finished step")

endmodule

### hdl/bpe_alu.sv
// ----------------------------------------------------------------------------
// bpe_alu
// shared saturating arithmetic unit: add, negate, min, max with a registered result, and
// a rounded fixed-point multiply taking one operand digit per cycle
// ----------------------------------------------------------------------------
module bpe_alu #(
  parameter int DATA_WIDTH = bpe_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = bpe_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpe_pkg::alu_ctl_t            ctl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res
);
  import bpe_pkg::*;

  localparam int NCH   = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BW    = NCH * MUL_CHUNK;
  localparam int ACC_W = DATA_WIDTH + BW;
  localparam int PP_W  = DATA_WIDTH + MUL_CHUNK;
  localparam int PR_W  = 2 * DATA_WIDTH + 1;
  localparam int CNT_W = $clog2(NCH);
  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [PR_W-1:0] RND = PR_W'(1) << (FRAC_BITS - 1);

  alu_state_t state_r, state_nxt;
  logic done_r, done_nxt;

  logic [DATA_WIDTH-1:0]        mag_a_r;
  logic [BW-1:0]                b_sh_r;
  logic [ACC_W-1:0]             acc_r;
  logic                         neg_r;
  logic [CNT_W-1:0]             cnt_r;
  logic signed [DATA_WIDTH-1:0] res_r;

  logic [DATA_WIDTH:0]          sum;
  logic signed [DATA_WIDTH-1:0] simple_res;
  logic [DATA_WIDTH-1:0]        mag_a, mag_b;
  logic [PP_W-1:0]              pp;
  logic [ACC_W-1:0]             acc_sum;
  logic [PR_W-1:0]              rounded, shifted;
  logic [DATA_WIDTH-1:0]        mag_q;
  logic                         over;
  logic signed [DATA_WIDTH-1:0] fin_res;

  // add, negate, max and min ops
  always_comb begin
    sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    case (ctl.op)
      OP_ADD: begin
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
          simple_res = sum[DATA_WIDTH] ? Q_MIN : Q_MAX;
        end else begin
          simple_res = $signed(sum[DATA_WIDTH-1:0]);
        end
      end
      OP_NEG: simple_res = (a == Q_MIN) ? Q_MAX : -a;
      OP_MAX: simple_res = (a > b) ? a : b;
      OP_MIN: simple_res = (a < b) ? a : b;
      default: simple_res = a;
    endcase
  end

  // operand magnitudes for the multiplier
  assign mag_a = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
  assign mag_b = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);

  // digit step, most significant digit of b first
  assign pp      = PP_W'(mag_a_r) * PP_W'(b_sh_r[BW-1 -: MUL_CHUNK]);
  assign acc_sum = (acc_r << MUL_CHUNK) + ACC_W'(pp);

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    rounded = PR_W'(acc_r[2*DATA_WIDTH-1:0]) + RND;
    shifted = rounded >> FRAC_BITS;
    over    = |shifted[PR_W-1:DATA_WIDTH-1];
    mag_q   = shifted[DATA_WIDTH-1:0];
    if (over) begin
      fin_res = neg_r ? Q_MIN : Q_MAX;
    end else begin
      fin_res = neg_r ? -$signed(mag_q) : $signed(mag_q);
    end
  end

  // unit sequencing
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      AS_IDLE: begin
        if (ctl.start) begin
          if (ctl.op == OP_MUL) begin
            state_nxt = AS_ACC;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
      AS_ACC: begin
        if (cnt_r == CNT_W'(NCH - 1)) begin
          state_nxt = AS_FIN;
        end
      end
      AS_FIN: begin
        done_nxt  = 1'b1;
        state_nxt = AS_IDLE;
      end
      default: state_nxt = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      AS_IDLE: begin
        if (ctl.start) begin
          if (ctl.op == OP_MUL) begin
            mag_a_r <= mag_a;
            b_sh_r  <= BW'(mag_b);
            acc_r   <= '0;
            neg_r   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            cnt_r   <= '0;
          end else begin
            res_r <= simple_res;
          end
        end
      end
      AS_ACC: begin
        acc_r  <= acc_sum;
        b_sh_r <= b_sh_r << MUL_CHUNK;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      AS_FIN: res_r <= fin_res;
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### dv/boat_plant_euler_step_unit_tb.sv
// ----------------------------------------------------------------------------
// boat_plant_euler_step_unit_tb
// Drives ticks (motor power, rudder setpoint) into the euler step unit and
// checks every out_ beat against an in-bench fixed-point copy of the four
// plants. Directed ticks cover clamp limits, a zero time step, writes to
// unused register indexes and one long receiver hold. Random phases then run
// well-formed held commands mixed with raw 32-bit words across several time
// step and speed gain settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module boat_plant_euler_step_unit_tb;
  import bpe_pkg::*;

  localparam int DW = bpe_pkg::DEF_DATA_WIDTH;
  localparam int FB = bpe_pkg::DEF_FRAC_BITS;

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DW-1){1'b0}}};

  // plant coefficients in q.32
  localparam longint ONE_Q32     = 64'sd4294967296;
  localparam longint DEG2RAD_Q32 = 64'sd74961321;
  localparam longint RAD2DEG_Q32 = 64'sd246083499208;
  localparam longint RPM_Q32     = 64'sd41013916535;
  localparam longint P0015_Q32   = 64'sd64424509;
  localparam longint P099_Q32    = 64'sd4252017623;

  localparam logic [CFG_W-1:0] DEFAULT_SETTING = CFG_W'(655);
  localparam logic [CFG_W-1:0] CFG_TOP         = {CFG_W{1'b1}};
  localparam int NUM_REGS        = 2;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 8;
  localparam int STEP_LATENCY    = 200;
  localparam int LONG_HOLD       = 1500;
  localparam int MAX_REPORTS     = 40;
  // room for ~1950 ticks with the block's step time, sender gaps and receiver stalls, several times over
  localparam int CYCLE_LIMIT     = 3_000_000;

  // q.32 constant to the block's format, round half away from zero
  function automatic fix_t q32_to_fix(input longint k);
    logic [63:0] mag;
    mag = (k < 0) ? 64'(-k) : 64'(k);
    mag = (mag + (64'd1 << (31 - FB))) >> (32 - FB);
    if (mag > 64'(FIX_MAX)) return (k < 0) ? FIX_MIN : FIX_MAX;
    return (k < 0) ? -fix_t'(mag[DW-1:0]) : fix_t'(mag[DW-1:0]);
  endfunction

  localparam fix_t K_ONE     = q32_to_fix(ONE_Q32);
  localparam fix_t K_TWENTY  = q32_to_fix(20 * ONE_Q32);
  localparam fix_t K_NEG20   = q32_to_fix(-20 * ONE_Q32);
  localparam fix_t K_DEG2RAD = q32_to_fix(DEG2RAD_Q32);
  localparam fix_t K_M2      = q32_to_fix(-2 * ONE_Q32);
  localparam fix_t K_P500    = q32_to_fix(500 * ONE_Q32);
  localparam fix_t K_MHALF   = q32_to_fix(-(ONE_Q32 / 2));
  localparam fix_t K_M075    = q32_to_fix(-3 * (ONE_Q32 / 4));
  localparam fix_t K_P0015   = q32_to_fix(P0015_Q32);
  localparam fix_t K_M3      = q32_to_fix(-3 * ONE_Q32);
  localparam fix_t K_M099    = q32_to_fix(-P099_Q32);
  localparam fix_t K_HALF    = q32_to_fix(ONE_Q32 / 2);
  localparam fix_t K_RPM     = q32_to_fix(RPM_Q32);
  localparam fix_t K_RAD2DEG = q32_to_fix(RAD2DEG_Q32);

  typedef struct packed {
    fix_t shaft_speed;
    fix_t prop_accel;
    fix_t hull_speed;
    fix_t hull_accel;
    fix_t rudder_angle;
    fix_t rudder_rate;
    fix_t yaw_angle;
    fix_t yaw_rate;
  } plant_t;

  typedef struct packed {
    fix_t rpm;
    fix_t speed;
    fix_t yaw;
  } reading_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fix_t in_motor_power = '0;
  fix_t in_rudder_setpoint = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fix_t out_shaft_rpm;
  fix_t out_boat_speed_out;
  fix_t out_yaw_deg;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // model state and settings
  plant_t plant;
  fix_t step_dt;
  fix_t gain_sq;
  reading_t expected_readings[$];

  // held commands for well-formed random ticks
  fix_t hold_pwr = '0;
  fix_t hold_rdeg = '0;

  bit no_idle = 1'b0;
  int rx_hold_cycles = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int cycles_run = 0;

  boat_plant_euler_step_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_motor_power     (in_motor_power),
    .in_rudder_setpoint (in_rudder_setpoint),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_shaft_rpm      (out_shaft_rpm),
    .out_boat_speed_out (out_boat_speed_out),
    .out_yaw_deg        (out_yaw_deg),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // saturating fixed-point arithmetic
  function automatic fix_t sat_add(input fix_t a, input fix_t b);
    logic signed [DW:0] s;
    s = a + b;
    if (s > FIX_MAX) return FIX_MAX;
    if (s < FIX_MIN) return FIX_MIN;
    return s[DW-1:0];
  endfunction

  function automatic fix_t sat_neg(input fix_t a);
    return (a == FIX_MIN) ? FIX_MAX : -a;
  endfunction

  function automatic fix_t fix_mul(input fix_t a, input fix_t b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [2*DW-1:0] prod;
    logic neg;
    neg  = a[DW-1] ^ b[DW-1];
    ma   = a[DW-1] ? -a : a;
    mb   = b[DW-1] ? -b : b;
    prod = (2*DW)'(ma) * (2*DW)'(mb);
    prod = (prod + ((2*DW)'(1) << (FB - 1))) >> FB;
    if (neg) return (prod > (2*DW)'(FIX_MAX)) ? FIX_MIN : -fix_t'(prod[DW-1:0]);
    return (prod > (2*DW)'(FIX_MAX)) ? FIX_MAX : fix_t'(prod[DW-1:0]);
  endfunction

  function automatic fix_t clamp(input fix_t v, input fix_t lo, input fix_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one euler step of all four plants, derivatives from the old state
  function automatic reading_t advance_plant(input fix_t pwr_cmd, input fix_t rdeg_cmd);
    fix_t pwr, rrad, pd0, pd1, vd0, vd1, rd0, rd1, yd0, yd1, sf;
    reading_t r;
    pwr  = clamp(pwr_cmd, '0, K_ONE);
    rrad = fix_mul(clamp(rdeg_cmd, K_NEG20, K_TWENTY), K_DEG2RAD);
    pd0  = sat_add(sat_neg(plant.shaft_speed), plant.prop_accel);
    pd1  = sat_add(fix_mul(K_M2, plant.prop_accel), fix_mul(K_P500, pwr));
    vd0  = sat_add(fix_mul(K_MHALF, plant.hull_speed), plant.hull_accel);
    vd1  = sat_add(fix_mul(K_M075, plant.hull_accel), fix_mul(K_P0015, plant.shaft_speed));
    rd0  = plant.rudder_rate;
    rd1  = sat_add(sat_add(sat_neg(plant.rudder_angle), fix_mul(K_M3, plant.rudder_rate)),
                   rrad);
    sf   = fix_mul(fix_mul(plant.hull_speed, plant.hull_speed), gain_sq);
    yd0  = plant.yaw_rate;
    yd1  = sat_add(fix_mul(K_M099, plant.yaw_rate),
                   fix_mul(fix_mul(K_HALF, plant.rudder_angle), sf));
    plant.shaft_speed  = sat_add(plant.shaft_speed, fix_mul(pd0, step_dt));
    plant.prop_accel   = sat_add(plant.prop_accel, fix_mul(pd1, step_dt));
    plant.hull_speed   = sat_add(plant.hull_speed, fix_mul(vd0, step_dt));
    plant.hull_accel   = sat_add(plant.hull_accel, fix_mul(vd1, step_dt));
    plant.rudder_angle = sat_add(plant.rudder_angle, fix_mul(rd0, step_dt));
    plant.rudder_rate  = sat_add(plant.rudder_rate, fix_mul(rd1, step_dt));
    plant.yaw_angle    = sat_add(plant.yaw_angle, fix_mul(yd0, step_dt));
    plant.yaw_rate     = sat_add(plant.yaw_rate, fix_mul(yd1, step_dt));
    r.rpm   = fix_mul(plant.shaft_speed, K_RPM);
    r.speed = plant.hull_speed;
    r.yaw   = fix_mul(plant.yaw_angle, K_RAD2DEG);
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // motor power: held command, clamp edges, or a raw word
  function automatic fix_t next_power();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return fix_t'($urandom());
    if (r < 16) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return K_ONE;
        2: return K_ONE + 1;
        3: return -1;
        4: return FIX_MAX;
        default: return FIX_MIN;
      endcase
    end
    if ($urandom_range(0, 19) == 0) hold_pwr = fix_t'($urandom_range(0, K_ONE));
    return hold_pwr;
  endfunction

  // rudder setpoint: held command, clamp edges, or a raw word
  function automatic fix_t next_rudder();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return fix_t'($urandom());
    if (r < 16) begin
      case ($urandom_range(0, 5))
        0: return K_TWENTY;
        1: return K_NEG20;
        2: return K_TWENTY + 1;
        3: return K_NEG20 - 1;
        4: return FIX_MAX;
        default: return FIX_MIN;
      endcase
    end
    if ($urandom_range(0, 9) == 0) hold_rdeg = fix_t'($urandom_range(0, 2 * K_TWENTY)) - K_TWENTY;
    return hold_rdeg;
  endfunction

  // one tick beat on the input channel
  task automatic send_tick(input fix_t pwr, input fix_t rdeg);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_motor_power     <= pwr;
    in_rudder_setpoint <= rdeg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(advance_plant(pwr, rdeg));
    ticks_sent++;
  endtask

  task automatic pause_input();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // one register write beat
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TIME_STEP) begin
      step_dt = '0;
      step_dt[CFG_W-1:0] = data;
    end else if (idx == REG_SPEED_GAIN) begin
      gain_sq = '0;
      gain_sq[CFG_W-1:0] = data;
    end
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] sg);
    pause_input();
    wait_drained();
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_SPEED_GAIN, sg);
  endtask

  // clamp limits and extremes of both fields at the reset settings
  task automatic test_clamp_extremes();
    send_tick('0, '0);
    send_tick(K_ONE, K_TWENTY);
    send_tick(FIX_MAX, FIX_MAX);
    send_tick(FIX_MIN, FIX_MIN);
    send_tick(K_ONE + 1, K_TWENTY + 1);
    send_tick(-1, K_NEG20 - 1);
    send_tick(K_ONE - 1, K_TWENTY - 1);
    send_tick(K_ONE / 2, K_NEG20);
    send_tick(-K_ONE, K_NEG20 + 1);
    send_tick(1, 1);
    send_tick(K_ONE, -1);
    send_tick(K_ONE, K_TWENTY);
    send_tick(K_ONE, K_NEG20);
    send_tick(fix_t'(32'h5555_5555), fix_t'(32'hAAAA_AAAA));
  endtask

  // zero time step freezes the plants, outputs are still reported
  task automatic test_zero_time_step();
    reconfigure('0, DEFAULT_SETTING);
    repeat (5) send_tick(next_power(), next_rudder());
    reconfigure(DEFAULT_SETTING, DEFAULT_SETTING);
  endtask

  // writes to indexes past the last register must leave settings alone
  task automatic test_unused_index();
    pause_input();
    wait_drained();
    repeat (3) write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)),
                         CFG_W'($urandom()));
    write_reg({CFG_IDX_W{1'b1}}, CFG_TOP);
    repeat (4) send_tick(next_power(), next_rudder());
  endtask

  // long receiver hold with back-to-back ticks, then a full drain
  task automatic test_backpressure();
    pause_input();
    wait_drained();
    rx_hold_cycles = LONG_HOLD;
    no_idle = 1'b1;
    repeat (8) send_tick(next_power(), next_rudder());
    no_idle = 1'b0;
    pause_input();
    wait_drained();
  endtask

  // random ticks over a spread of settings, saturation last
  task automatic test_random_phases();
    logic [CFG_W-1:0] dt;
    logic [CFG_W-1:0] sg;
    int p;
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin dt = DEFAULT_SETTING;    sg = DEFAULT_SETTING; end
        1: begin dt = CFG_W'(6554);       sg = CFG_W'(6554); end
        2: begin dt = CFG_W'($urandom_range(1, 65536)); sg = CFG_W'($urandom()); end
        3: begin dt = CFG_W'(65536);      sg = CFG_W'(65536); end
        4: begin dt = CFG_W'(1);          sg = '0; end
        5: begin dt = '0;                 sg = CFG_W'($urandom()); end
        6: begin dt = CFG_W'(3277);       sg = CFG_TOP; end
        default: begin dt = CFG_TOP;      sg = CFG_TOP; end
      endcase
      reconfigure(dt, sg);
      no_idle = (p == 1);
      repeat (ITEMS_PER_PHASE) send_tick(next_power(), next_rudder());
      no_idle = 1'b0;
    end
  endtask

  // receiver: random ready runs and stalls, steady ready while no_idle, or a long hold on request
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic report_mismatch(input string field, input fix_t want, input fix_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // compare each result beat with the oldest expected reading
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with no tick pending, actual %0d %0d %0d", $time,
                   out_shaft_rpm, out_boat_speed_out, out_yaw_deg);
      end else begin
        want = expected_readings.pop_front();
        if (out_shaft_rpm !== want.rpm) report_mismatch("shaft_rpm", want.rpm, out_shaft_rpm);
        if (out_boat_speed_out !== want.speed)
          report_mismatch("boat_speed_out", want.speed, out_boat_speed_out);
        if (out_yaw_deg !== want.yaw) report_mismatch("yaw_deg", want.yaw, out_yaw_deg);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main_seq
    plant   = '0;
    step_dt = '0;
    gain_sq = '0;
    step_dt[CFG_W-1:0] = DEFAULT_SETTING;
    gain_sq[CFG_W-1:0] = DEFAULT_SETTING;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clamp_extremes();
    test_zero_time_step();
    test_unused_index();
    test_backpressure();
    test_random_phases();

    pause_input();
    wait_drained();
    repeat (STEP_LATENCY) @(posedge clk);

    $display("%0d ticks, %0d result beats checked, %0d register writes", ticks_sent,
             results_seen, reg_writes);
    $display("covered clamp edges, zero and top time step, unused indexes, held-off results");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
